[src/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants for the text console cursor control
// Character codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package tcc_pkg;

	// Character codes with special meaning.
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_ESCAPE    = 8'd27;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	// Register reset values.
	localparam logic [7:0] WIDTH_RESET  = 8'd80;
	localparam logic [7:0] HEIGHT_RESET = 8'd25;

	// Display action codes.
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SCROLL = 1'b1;

	// One result item.
	typedef struct packed {
		logic       action;
		logic [7:0] row;
		logic [7:0] column;
		logic [7:0] glyph;
		logic       final_result;
	} result_t;

	// Outcome of one character: new cursor and up to two results.
	typedef struct packed {
		logic [7:0] row;
		logic [7:0] column;
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} step_t;

endpackage

[src/tcc_step.sv]
// ----------------------------------------------------------------------------
// tcc_step: cursor update for one character
// Clamps the cursor into the display, applies the character and forms the
// display actions that it causes.
// ----------------------------------------------------------------------------
module tcc_step (
	input  logic [7:0]     char_code,
	input  logic [7:0]     screen_width,
	input  logic [7:0]     screen_height,
	input  logic [7:0]     cur_row,
	input  logic [7:0]     cur_column,
	output tcc_pkg::step_t step
);

	logic [7:0] w;
	logic [7:0] h;
	logic [7:0] r0;
	logic [7:0] c0;
	logic [8:0] c_inc;
	logic [8:0] r_inc;
	logic       col_wrap;
	logic [8:0] r_nl;
	tcc_pkg::result_t write_res;
	tcc_pkg::result_t scroll_res;

	// A size of zero acts as one; a cursor beyond the display is pulled in.
	assign w  = (screen_width  == 8'd0) ? 8'd1 : screen_width;
	assign h  = (screen_height == 8'd0) ? 8'd1 : screen_height;
	assign r0 = (cur_row    >= h) ? h - 8'd1 : cur_row;
	assign c0 = (cur_column >= w) ? w - 8'd1 : cur_column;

	assign c_inc    = {1'b0, c0} + 9'd1;
	assign r_inc    = {1'b0, r0} + 9'd1;
	assign col_wrap = (c_inc >= {1'b0, w});
	assign r_nl     = (c0 != 8'd0) ? r_inc : {1'b0, r0};

	assign scroll_res = '{action: tcc_pkg::ACT_SCROLL, row: 8'd0, column: 8'd0,
		glyph: 8'd0, final_result: 1'b1};

	// Decode the character and form the results.
	always_comb begin
		write_res = '{action: tcc_pkg::ACT_WRITE, row: r0, column: c0,
			glyph: char_code, final_result: 1'b1};
		step.row    = r0;
		step.column = c0;
		step.count  = 2'd0;
		step.res0   = write_res;
		step.res1   = scroll_res;
		unique case (char_code)
			tcc_pkg::CH_NEWLINE: begin
				step.column = 8'd0;
				if (r_nl >= {1'b0, h}) begin
					step.row   = h - 8'd1;
					step.count = 2'd1;
					step.res0  = scroll_res;
				end else begin
					step.row = r_nl[7:0];
				end
			end
			tcc_pkg::CH_BACKSPACE: begin
				if (c0 != 8'd0) begin
					step.column = c0 - 8'd1;
				end else if (r0 != 8'd0) begin
					step.column = w - 8'd1;
					step.row    = r0 - 8'd1;
				end
				step.count        = 2'd1;
				step.res0.row     = step.row;
				step.res0.column  = step.column;
				step.res0.glyph   = tcc_pkg::CH_SPACE;
			end
			tcc_pkg::CH_ESCAPE: begin
				step.count = 2'd0;
			end
			default: begin
				// Printed character: write, advance with wrap, scroll past the last row.
				if (col_wrap) begin
					step.column = 8'd0;
					if (r_inc >= {1'b0, h}) begin
						step.row                = h - 8'd1;
						step.count              = 2'd2;
						step.res0.final_result  = 1'b0;
					end else begin
						step.row   = r_inc[7:0];
						step.count = 2'd1;
					end
				end else begin
					step.column = c_inc[7:0];
					step.count  = 2'd1;
				end
			end
		endcase
	end

endmodule

[src/text_console_cursor_control.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_control: cursor tracking for a character display
// Takes one character per item, keeps the cursor cell and issues cell
// writes and scroll commands through a three-entry result queue.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_stall    | char_code
//  output   | out_valid / out_stall  | action, cell_row, cell_column, glyph,
//           |                        | final_result
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A character is handled in the cycle it is accepted: the cursor registers
// and the result queue load at that edge, and the first result is offered in
// the next cycle. One item can be taken every cycle while the queue holds at
// most one result, so while the output does not stall the rate is one item per
// cycle for single-result items and set by the output drain otherwise.
// Reset clears the cursor, restores the sizes to 80 by 25 and empties the
// queue. A stall on the output holds the head result and fills the queue.
module text_console_cursor_control (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   char_code,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         action,
	output logic [7:0]                   cell_row,
	output logic [7:0]                   cell_column,
	output logic [7:0]                   glyph,
	output logic                         final_result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                   cfg_data
);

	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [7:0] row_q;
	logic [7:0] column_q;
	logic [1:0] count_q;
	logic [1:0] count_next;
	logic [1:0] base;
	logic       push;
	logic       pop;
	tcc_pkg::step_t   step;
	tcc_pkg::result_t queue_q [3];
	tcc_pkg::result_t queue_next [3];

	tcc_step u_step (
		.char_code     (char_code),
		.screen_width  (width_q),
		.screen_height (height_q),
		.cur_row       (row_q),
		.cur_column    (column_q),
		.step          (step)
	);

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign in_stall  = (count_q > 2'd1);
	assign push      = in_valid && !in_stall;
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tcc_pkg::WIDTH_RESET;
			height_q <= tcc_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tcc_pkg::REG_SCREEN_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == tcc_pkg::REG_SCREEN_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// Cursor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= 8'd0;
			column_q <= 8'd0;
		end else if (push) begin
			row_q    <= step.row;
			column_q <= step.column;
		end
	end

	// Result queue: shift down on a pop, append the new results behind.
	assign base = count_q - {1'b0, pop};

	always_comb begin
		queue_next[0] = pop ? queue_q[1] : queue_q[0];
		queue_next[1] = pop ? queue_q[2] : queue_q[1];
		queue_next[2] = queue_q[2];
		if (push && step.count != 2'd0) begin
			queue_next[base] = step.res0;
			if (step.count == 2'd2) begin
				queue_next[base + 2'd1] = step.res1;
			end
		end
		count_next = base + (push ? step.count : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			queue_q[i] <= queue_next[i];
		end
	end

	// Head of the queue drives the output.
	assign action       = queue_q[0].action;
	assign cell_row     = queue_q[0].row;
	assign cell_column  = queue_q[0].column;
	assign glyph        = queue_q[0].glyph;
	assign final_result = queue_q[0].final_result;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for text_console_cursor_control
// Drives character items and size register writes, tracks the cursor in a
// behavioral copy of the block and checks every display action in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned IDLE_PCT    = 12;
	localparam int unsigned PHASES      = 27;
	localparam int unsigned PHASE_ITEMS = 50;

	// Tracks cursor and sizes, and holds the display actions still owed.
	class cursor_tracker;
		logic [7:0]       width;
		logic [7:0]       height;
		logic [7:0]       row;
		logic [7:0]       col;
		tcc_pkg::result_t owed_actions[$];
		int               errors;

		function new();
			width  = tcc_pkg::WIDTH_RESET;
			height = tcc_pkg::HEIGHT_RESET;
			row    = '0;
			col    = '0;
			errors = 0;
		endfunction

		function int pending();
			return owed_actions.size();
		endfunction

		function void set_register(logic [tcc_pkg::CFG_IDX_W-1:0] idx,
				logic [7:0] value);
			if (idx == tcc_pkg::REG_SCREEN_WIDTH) begin
				width = value;
			end else if (idx == tcc_pkg::REG_SCREEN_HEIGHT) begin
				height = value;
			end
		endfunction

		function void owe(logic act, logic [7:0] r, logic [7:0] c, logic [7:0] g,
				logic fin);
			tcc_pkg::result_t res;
			res.action       = act;
			res.row          = r;
			res.column       = c;
			res.glyph        = g;
			res.final_result = fin;
			owed_actions.push_back(res);
		endfunction

		// Works out the actions that one accepted character causes.
		function void note_char(logic [7:0] ch);
			logic [7:0] w;
			logic [7:0] h;
			logic [7:0] r;
			logic [7:0] c;
			logic       scroll;
			w = (width == 0) ? 8'd1 : width;
			h = (height == 0) ? 8'd1 : height;
			// A size lowered under the cursor pulls it back onto the display.
			if (row >= h) row = h - 8'd1;
			if (col >= w) col = w - 8'd1;
			unique case (ch)
				tcc_pkg::CH_NEWLINE: begin
					if (col != 0) row = row + 8'd1;
					col = '0;
					if (row >= h) begin
						row = h - 8'd1;
						owe(tcc_pkg::ACT_SCROLL, '0, '0, '0, 1'b1);
					end
				end
				tcc_pkg::CH_BACKSPACE: begin
					if (col != 0) begin
						col = col - 8'd1;
					end else if (row != 0) begin
						col = w - 8'd1;
						row = row - 8'd1;
					end
					owe(tcc_pkg::ACT_WRITE, row, col, tcc_pkg::CH_SPACE, 1'b1);
				end
				tcc_pkg::CH_ESCAPE: begin
				end
				default: begin
					r = row;
					c = col;
					col = col + 8'd1;
					if (col >= w) begin
						row = row + 8'd1;
						col = '0;
					end
					scroll = (row >= h);
					owe(tcc_pkg::ACT_WRITE, r, c, ch, !scroll);
					if (scroll) begin
						row = h - 8'd1;
						owe(tcc_pkg::ACT_SCROLL, '0, '0, '0, 1'b1);
					end
				end
			endcase
		endfunction

		// Compares one accepted action with the oldest one owed.
		function void check_action(tcc_pkg::result_t got);
			tcc_pkg::result_t want;
			if (owed_actions.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: unexpected action act=%0d row=%0d col=%0d glyph=%0d fin=%0d",
						$time, got.action, got.row, got.column, got.glyph,
						got.final_result);
				end
				return;
			end
			want = owed_actions.pop_front();
			if (want.action != got.action || want.row != got.row ||
					want.column != got.column || want.glyph != got.glyph ||
					want.final_result != got.final_result) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch expected act=%0d row=%0d col=%0d glyph=%0d fin=%0d",
						$time, want.action, want.row, want.column, want.glyph,
						want.final_result);
					$display("%0t:          actual   act=%0d row=%0d col=%0d glyph=%0d fin=%0d",
						$time, got.action, got.row, got.column, got.glyph,
						got.final_result);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    char_code;
	logic                          out_valid;
	logic                          out_stall;
	logic                          action;
	logic [7:0]                    cell_row;
	logic [7:0]                    cell_column;
	logic [7:0]                    glyph;
	logic                          final_result;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	bit                            steady;
	cursor_tracker                 tracker;

	text_console_cursor_control DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.cell_row     (cell_row),
		.cell_column  (cell_column),
		.glyph        (glyph),
		.final_result (final_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Output stall, random except during the steady stretch.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Monitor: checks actions first, then notes characters and register writes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				tracker.check_action('{action, cell_row, cell_column, glyph, final_result});
			end
			if (in_valid && !in_stall) begin
				tracker.note_char(char_code);
			end
			if (cfg_valid && cfg_ready) begin
				tracker.set_register(cfg_index, cfg_data);
			end
		end
	end

	// Watchdog on cycles in which no channel moves an item.
	initial begin
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Sends one character item; entered and left at a falling edge.
	task automatic send_char(logic [7:0] ch);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= ch;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops input and waits until every owed action has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the selected size registers back to back.
	task automatic write_sizes(bit do_w, bit do_h, logic [7:0] w, logic [7:0] h);
		for (int i = 0; i < 2; i++) begin
			if ((i == 0) ? do_w : do_h) begin
				cfg_valid <= 1'b1;
				cfg_index <= (i == 0) ? tcc_pkg::REG_SCREEN_WIDTH :
					tcc_pkg::REG_SCREEN_HEIGHT;
				cfg_data  <= (i == 0) ? w : h;
				do @(posedge clk); while (!cfg_ready);
				@(negedge clk);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	// Sizes lean to the extremes and to small displays that wrap and scroll often.
	function automatic logic [7:0] pick_size();
		unique case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd255;
			4, 5: return 8'($urandom_range(1, 255));
			default: return 8'($urandom_range(1, 12));
		endcase
	endfunction

	// Control codes come often enough to move the cursor in every direction.
	function automatic logic [7:0] pick_char();
		int unsigned n;
		n = $urandom_range(0, 99);
		if (n < 14) return tcc_pkg::CH_NEWLINE;
		if (n < 28) return tcc_pkg::CH_BACKSPACE;
		if (n < 32) return tcc_pkg::CH_ESCAPE;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		tracker   = new();
		steady    = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_code = '0;
		cfg_valid = 1'b0;
		cfg_index = tcc_pkg::REG_SCREEN_WIDTH;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset sizes: backspace at home, byte extremes, escape, both newline
		// cases and a backspace that wraps to the end of the row above.
		send_char(tcc_pkg::CH_BACKSPACE);
		send_char(8'd0);
		send_char(8'd255);
		send_char(8'd65);
		send_char(tcc_pkg::CH_ESCAPE);
		send_char(tcc_pkg::CH_NEWLINE);
		send_char(tcc_pkg::CH_NEWLINE);
		send_char(tcc_pkg::CH_BACKSPACE);
		send_char(tcc_pkg::CH_BACKSPACE);
		wait_idle();

		// One-cell display: every glyph scrolls.
		write_sizes(1'b1, 1'b1, 8'd1, 8'd1);
		send_char(8'd120);
		send_char(tcc_pkg::CH_NEWLINE);
		send_char(tcc_pkg::CH_BACKSPACE);
		wait_idle();

		// Two by two: wrap into the last row, then a newline that scrolls.
		write_sizes(1'b1, 1'b1, 8'd2, 8'd2);
		send_char(8'd65);
		send_char(8'd66);
		send_char(8'd67);
		send_char(tcc_pkg::CH_NEWLINE);
		wait_idle();

		// Zero sizes behave as one.
		write_sizes(1'b1, 1'b1, 8'd0, 8'd0);
		send_char(8'd97);
		send_char(tcc_pkg::CH_BACKSPACE);
		wait_idle();

		// Largest display.
		write_sizes(1'b1, 1'b1, 8'd255, 8'd255);
		send_char(tcc_pkg::CH_SPACE);
		send_char(8'd126);
		send_char(tcc_pkg::CH_NEWLINE);
		wait_idle();

		// Random phases; the cursor carries over, so lowered sizes clamp it.
		for (int p = 0; p < PHASES; p++) begin
			int unsigned sel;
			sel    = $urandom_range(1, 3);
			steady = (p >= 8 && p < 13);
			write_sizes(sel[0], sel[1], pick_size(), pick_size());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_char(pick_char());
			end
			wait_idle();
		end

		steady = 1'b0;
		repeat (8) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
